// ----- rtl/core/scharr_gradient_magnitude_core_defines.svh -----
// assertion macros for the scharr gradient magnitude core
`ifndef SCHARR_GRADIENT_MAGNITUDE_CORE_DEFINES_SVH
`define SCHARR_GRADIENT_MAGNITUDE_CORE_DEFINES_SVH
// property that must hold at every edge out of reset
`define SGM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication checked at the next edge
`define SGM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- rtl/core/sgm_pkg.sv -----
// shared types, constants and a function for the scharr gradient magnitude core
package sgm_pkg;
  localparam int MaxWidth = 1024;
  localparam int ColW = $clog2(MaxWidth);
  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;

  typedef logic [23:0] pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } result_t;

  // one scharr gradient (gx, or gy by argument order) of one channel over a 3x3 window
  function automatic logic signed [12:0] scharr_gx(input logic [7:0] a0, input logic [7:0] a1,
                                                    input logic [7:0] a2, input logic [7:0] c0,
                                                    input logic [7:0] c1, input logic [7:0] c2);
    logic signed [12:0] t, b;
    t = 13'(a0) * 13'sd3 + 13'(a1) * 13'sd10 + 13'(a2) * 13'sd3;
    b = 13'(c0) * 13'sd3 + 13'(c1) * 13'sd10 + 13'(c2) * 13'sd3;
    return t - b;
  endfunction
endpackage

// ----- rtl/core/sgm_line_ram.sv -----
// one line buffer: synchronous ram with registered read
module sgm_line_ram import sgm_pkg::*; (
  input  logic            clk,
  input  logic            we,
  input  logic [ColW-1:0] addr,
  input  pixel_t          wdata,
  input  logic            re,
  output pixel_t          rdata
);
  pixel_t mem [MaxWidth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (re) rdata <= mem[addr];
  end
endmodule

// ----- rtl/core/sgm_isqrt.sv -----
// sequential integer square root of three channels, one bit per cycle, saturated
module sgm_isqrt import sgm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [16:0] sq_r,
  input  logic [16:0] sq_g,
  input  logic [16:0] sq_b,
  output logic        busy,
  output logic        done,
  output logic [7:0]  root_r,
  output logic [7:0]  root_g,
  output logic [7:0]  root_b
);
  logic [16:0] vr, vg, vb;
  logic [7:0]  bitm;
  logic [7:0]  tr, tg, tb;

  assign tr = root_r | bitm;
  assign tg = root_g | bitm;
  assign tb = root_b | bitm;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        bitm <= 8'h80;
        vr <= sq_r; vg <= sq_g; vb <= sq_b;
        root_r <= '0; root_g <= '0; root_b <= '0;
      end else if (busy) begin
        if (vr[16]) root_r <= 8'hff;
        else if (16'(tr) * 16'(tr) <= vr[15:0]) root_r <= tr;
        if (vg[16]) root_g <= 8'hff;
        else if (16'(tg) * 16'(tg) <= vg[15:0]) root_g <= tg;
        if (vb[16]) root_b <= 8'hff;
        else if (16'(tb) * 16'(tb) <= vb[15:0]) root_b <= tb;
        bitm <= bitm >> 1;
        if (bitm[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- rtl/core/scharr_gradient_magnitude_core.sv -----
// top level: line buffers, 3x3 window, scharr gradients and magnitude
// steps: line buffer read, window shift, gradient and square, bit-serial square root, then output
// a new pixel is accepted only after the previous one has left, so the square root unit sets the pace
// border pixels produce no output transfer
// synchronous reset clears counters, window and control; width 640, height 480
// line buffer contents are undefined until written
`include "scharr_gradient_magnitude_core_defines.svh"
module scharr_gradient_magnitude_core import sgm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red_magnitude,
  output logic [7:0]  green_magnitude,
  output logic [7:0]  blue_magnitude,
  output logic        frame_done
);
  typedef enum logic [2:0] {S_IDLE, S_READ, S_SHIFT, S_GRAD, S_SQ, S_ROOT} state_t;
  state_t state;

  logic [10:0] image_width;
  logic [15:0] image_height;
  logic [10:0] wuse;
  logic [15:0] huse;
  logic [10:0] column_count;
  logic [15:0] row_count;
  logic [ColW-1:0] col;
  pixel_t pix;
  pixel_t up_rd, mid_rd;
  pixel_t win [3][3];
  logic emit, last;
  logic signed [12:0] gx [3];
  logic signed [12:0] gy [3];
  logic [16:0] sq [3];
  logic sq_start, sq_busy, sq_done;
  logic [7:0] rt_r, rt_g, rt_b;
  logic row_end, frame_end;
  logic load_res;
  result_t res;

  always_comb begin
    wuse = image_width < 11'd3 ? 11'd3 :
           (image_width > 11'(MaxWidth) ? 11'(MaxWidth) : image_width);
    huse = image_height < 16'd3 ? 16'd3 : image_height;
    col = column_count >= 11'(MaxWidth) ? ColW'(MaxWidth - 1) : column_count[ColW-1:0];
    row_end = column_count >= wuse - 11'd1;
    frame_end = row_end && row_count >= huse - 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 11'd640;
      image_height <= 16'd480;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegWidth:  image_width <= cfg_data[10:0];
        RegHeight: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = state == S_IDLE;
  wire accept = in_valid && in_ready;
  assign load_res = state == S_ROOT && !sq_busy && (!out_valid || out_ready);

  sgm_line_ram u_upper (.clk, .we(state == S_READ), .addr(col), .wdata(mid_rd),
                        .re(accept), .rdata(up_rd));
  sgm_line_ram u_middle (.clk, .we(state == S_READ), .addr(col), .wdata(pix),
                         .re(accept), .rdata(mid_rd));

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      gx[c] = scharr_gx(win[0][0][8*c +: 8], win[0][1][8*c +: 8], win[0][2][8*c +: 8],
                        win[2][0][8*c +: 8], win[2][1][8*c +: 8], win[2][2][8*c +: 8]);
      gy[c] = scharr_gx(win[0][0][8*c +: 8], win[1][0][8*c +: 8], win[2][0][8*c +: 8],
                        win[0][2][8*c +: 8], win[1][2][8*c +: 8], win[2][2][8*c +: 8]);
    end
  end

  assign sq_start = state == S_SQ;

  sgm_isqrt u_isqrt (.clk, .rst, .start(sq_start), .sq_r(sq[0]), .sq_g(sq[1]), .sq_b(sq[2]),
                     .busy(sq_busy), .done(sq_done), .root_r(rt_r), .root_g(rt_g),
                     .root_b(rt_b));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      column_count <= '0;
      row_count <= '0;
      out_valid <= 1'b0;
      emit <= 1'b0;
      last <= 1'b0;
      for (int r = 0; r < 3; r++) for (int c = 0; c < 3; c++) win[r][c] <= '0;
    end else begin
      if (load_res) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (accept) begin
          pix <= {blue_in, green_in, red_in};
          state <= S_READ;
        end
        S_READ: begin
          for (int r = 0; r < 3; r++) begin
            win[r][0] <= win[r][1];
            win[r][1] <= win[r][2];
          end
          win[0][2] <= up_rd;
          win[1][2] <= mid_rd;
          win[2][2] <= pix;
          emit <= column_count >= 11'd2 && row_count >= 16'd2;
          last <= frame_end;
          if (row_end) begin
            column_count <= '0;
            row_count <= frame_end ? '0 : row_count + 16'd1;
          end else begin
            column_count <= column_count + 11'd1;
          end
          state <= S_SHIFT;
        end
        S_SHIFT: state <= emit ? S_GRAD : S_IDLE;
        S_GRAD: state <= S_SQ;
        S_SQ: state <= S_ROOT;
        S_ROOT: if (load_res) begin
          res <= '{red: rt_r, green: rt_g, blue: rt_b, last: last};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_GRAD) begin
      for (int c = 0; c < 3; c++) begin
        sq[c] <= 17'(26'(gx[c] * gx[c]) + 26'(gy[c] * gy[c]) > 26'd65535 ? 17'h10000 :
                 17'(gx[c] * gx[c]) + 17'(gy[c] * gy[c]));
      end
    end
  end

  assign red_magnitude = res.red;
  assign green_magnitude = res.green;
  assign blue_magnitude = res.blue;
  assign frame_done = res.last;

  `SGM_ASSERT(a_no_accept_busy, !(accept && sq_busy), "input taken while root busy")
  `SGM_ASSERT_NEXT(a_done_out, state == S_ROOT && sq_done, out_valid, "result lost")
  `SGM_ASSERT(a_col_range, column_count <= 11'(MaxWidth), "column count out of range")
endmodule
